// File: rtl/core/dcbdr_pkg.sv
// Package for the daisy chain break detector: operation codes, register
// indexes, chain states and register reset values. No dependencies.
package dcbdr_pkg;

  typedef enum logic [1:0] {
    OP_REPORT = 2'd0,
    OP_TICK   = 2'd1,
    OP_EVAL   = 2'd2,
    OP_REINIT = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    REG_BREAK_THR = 3'd0,
    REG_START_THR = 3'd1,
    REG_WIN_LEN   = 3'd2,
    REG_VERIFY_THR = 3'd3,
    REG_MAX_READS = 3'd4,
    REG_MASK_MS   = 3'd5
  } reg_e;

  typedef enum logic [4:0] {
    CS_NORMAL  = 5'b00001,
    CS_BREAK   = 5'b00010,
    CS_VERIFY  = 5'b00100,
    CS_SUCCESS = 5'b01000,
    CS_FAILED  = 5'b10000
  } chain_st_e;

  typedef enum logic [3:0] {
    C_IDLE = 4'b0001,
    C_ADD  = 4'b0010,
    C_SCAN = 4'b0100,
    C_FIN  = 4'b1000
  } ctl_e;

  localparam logic [2:0] CODE_NORMAL  = 3'd0;
  localparam logic [2:0] CODE_BREAK   = 3'd1;
  localparam logic [2:0] CODE_VERIFY  = 3'd2;
  localparam logic [2:0] CODE_SUCCESS = 3'd3;
  localparam logic [2:0] CODE_FAILED  = 3'd4;

  localparam logic [15:0] RST_BREAK_THR  = 16'd25;
  localparam logic [15:0] RST_START_THR  = 16'd5;
  localparam logic [15:0] RST_WIN_LEN    = 16'd4000;
  localparam logic [15:0] RST_VERIFY_THR = 16'd5;
  localparam logic [7:0]  RST_MAX_READS  = 8'd5;
  localparam logic [15:0] RST_MASK_MS    = 16'd1000;

  function automatic logic [2:0] chain_code(chain_st_e st);
    logic [2:0] code;
    unique case (st)
      CS_NORMAL:  code = CODE_NORMAL;
      CS_BREAK:   code = CODE_BREAK;
      CS_VERIFY:  code = CODE_VERIFY;
      CS_SUCCESS: code = CODE_SUCCESS;
      CS_FAILED:  code = CODE_FAILED;
      default:    code = CODE_NORMAL;
    endcase
    return code;
  endfunction

endpackage

// File: rtl/core/dcbdr_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module dcbdr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/daisy_chain_break_detect_recover.sv
// Top level of the daisy chain break detector and recovery sequencer.
// Depends on dcbdr_pkg and dcbdr_ram.
//
// Error reports for a device on the chain pass through the add and finish
// states before the result strobe; ticks, reinitialize, reports for a device
// beyond the chain and evaluate steps that need no scan go straight to the
// finish state; an evaluate step that scans the error sums first walks the
// scan state over every device, since the sums sit in one RAM with a single
// read port and are read one device per cycle. Each word is accepted when
// start is high and busy is low, and each result word appears for exactly one
// cycle with result_valid_o high; the receiver cannot stall it. All sums are
// cleared at once by clearing a valid bit per device.
module daisy_chain_break_detect_recover #(
  parameter int CHAIN_LENGTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation_i,
  input  logic [3:0]  device_index_i,
  input  logic [7:0]  error_count_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output logic        result_valid_o,
  output logic [2:0]  machine_state_o,
  output logic [4:0]  break_position_o,
  output logic [7:0]  verify_attempts_o,
  output logic        recovered_o,
  output logic        status_report_o,
  output logic        reroute_start_o,
  output logic        comm_break_set_o,
  output logic        fault_raise_o,
  output logic        fault_clear_o,
  output logic        mask_expired_o
);

  import dcbdr_pkg::*;

  localparam int AW = (CHAIN_LENGTH > 1) ? $clog2(CHAIN_LENGTH) : 1;
  localparam logic [AW-1:0] LAST = AW'(CHAIN_LENGTH - 1);

  logic [15:0] brk_thr_q, start_thr_q, win_len_q, ver_thr_q, mask_ms_q;
  logic [7:0]  max_reads_q;

  ctl_e ctl_q, ctl_d;
  op_e  op_q;
  logic [3:0] dev_q;
  logic [7:0] cnt_q;

  chain_st_e fsm_q, fsm_d;
  logic        win_act_q, win_act_d;
  logic [15:0] win_rem_q, win_rem_d;
  logic [15:0] mask_rem_q, mask_rem_d;
  logic [4:0]  bp_q, bp_d;
  logic [7:0]  att_q, att_d;
  logic        succ_q, succ_d;
  logic        fail_q, fail_d;

  logic [(1 << AW)-1:0] valid_q;
  logic                 rd_valid_q;
  logic [AW-1:0]        raddr;
  logic [15:0]          rdata;
  logic                 we;
  logic [15:0]          wdata;
  logic [16:0]          sum;
  logic [15:0]          val;

  logic [AW-1:0] scan_k_q;
  logic          spike_q, found_q, all_q, bad_q;
  logic [AW-1:0] first_q;

  logic accept, dev_ok, scan_needed, clear_c;
  logic status_c, reroute_c, cbreak_c, fraise_c, fclear_c;

  logic        rv_q;
  logic [2:0]  ms_q;
  logic [4:0]  bpo_q;
  logic [7:0]  atto_q;
  logic        rec_q, stat_q, rr_q, cb_q, fr_q, fc_q, me_q;

  assign accept = start && !busy;
  assign busy = (ctl_q != C_IDLE);
  assign cfg_ready_o = 1'b1;
  assign dev_ok = (32'(device_index_i) < CHAIN_LENGTH);
  assign val = rd_valid_q ? rdata : 16'd0;
  assign sum = {1'b0, val} + {9'd0, cnt_q};
  assign wdata = sum[16] ? 16'hFFFF : sum[15:0];
  assign we = (ctl_q == C_ADD);

  assign scan_needed = (op_e'(operation_i) == OP_EVAL) &&
      (((fsm_q == CS_NORMAL) && !succ_q && (!win_act_q || (win_rem_q == 16'd0))) ||
       ((fsm_q == CS_VERIFY) && (att_q < max_reads_q)));

  dcbdr_ram #(
    .WIDTH(16),
    .DEPTH(CHAIN_LENGTH)
  ) u_sums (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(AW'(dev_q)),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_comb begin
    raddr = '0;
    ctl_d = ctl_q;
    unique case (ctl_q)
      C_IDLE: begin
        if (op_e'(operation_i) == OP_REPORT) begin
          raddr = AW'(device_index_i);
        end
        if (accept) begin
          if (op_e'(operation_i) == OP_REPORT) begin
            ctl_d = dev_ok ? C_ADD : C_FIN;
          end else begin
            ctl_d = scan_needed ? C_SCAN : C_FIN;
          end
        end
      end
      C_ADD: ctl_d = C_FIN;
      C_SCAN: begin
        raddr = scan_k_q + 1'b1;
        if (scan_k_q == LAST) begin
          ctl_d = C_FIN;
        end
      end
      C_FIN: ctl_d = C_IDLE;
      default: ctl_d = C_IDLE;
    endcase
  end

  always_comb begin
    fsm_d = fsm_q;
    win_act_d = win_act_q;
    win_rem_d = win_rem_q;
    mask_rem_d = mask_rem_q;
    bp_d = bp_q;
    att_d = att_q;
    succ_d = succ_q;
    fail_d = fail_q;
    clear_c = 1'b0;
    status_c = 1'b0;
    reroute_c = 1'b0;
    cbreak_c = 1'b0;
    fraise_c = 1'b0;
    fclear_c = 1'b0;
    if (ctl_q == C_FIN) begin
      unique case (op_q)
        OP_REPORT: begin
        end
        OP_TICK: begin
          if (win_act_q && (win_rem_q != 16'd0)) begin
            win_rem_d = win_rem_q - 16'd1;
          end
          if (mask_rem_q != 16'd0) begin
            mask_rem_d = mask_rem_q - 16'd1;
          end
        end
        OP_REINIT: begin
          mask_rem_d = mask_ms_q;
          win_act_d = 1'b0;
          win_rem_d = 16'd0;
          fsm_d = CS_NORMAL;
          bp_d = 5'd0;
          att_d = 8'd0;
          succ_d = 1'b0;
          fail_d = 1'b0;
          clear_c = 1'b1;
          status_c = 1'b1;
        end
        OP_EVAL: begin
          unique case (fsm_q)
            CS_NORMAL: begin
              if (succ_q) begin
                clear_c = 1'b1;
              end else if (!win_act_q) begin
                if (spike_q) begin
                  win_act_d = 1'b1;
                  win_rem_d = win_len_q;
                end else begin
                  clear_c = 1'b1;
                end
              end else if (win_rem_q == 16'd0) begin
                win_act_d = 1'b0;
                clear_c = 1'b1;
                if (found_q && all_q) begin
                  fsm_d = CS_BREAK;
                  bp_d = 5'(32'(first_q) + 1);
                  fraise_c = 1'b1;
                end
              end
            end
            CS_BREAK: begin
              status_c = 1'b1;
              reroute_c = 1'b1;
              cbreak_c = (bp_q > 5'd1);
              clear_c = 1'b1;
              fsm_d = CS_VERIFY;
            end
            CS_VERIFY: begin
              status_c = 1'b1;
              if (att_q >= max_reads_q) begin
                fsm_d = CS_FAILED;
              end else begin
                clear_c = 1'b1;
                if (!bad_q) begin
                  fsm_d = CS_SUCCESS;
                  succ_d = 1'b1;
                end
                att_d = att_q + 8'd1;
              end
            end
            CS_SUCCESS: begin
              status_c = 1'b1;
              fclear_c = 1'b1;
              fsm_d = CS_NORMAL;
            end
            CS_FAILED: begin
              if (!fail_q) begin
                status_c = 1'b1;
                succ_d = 1'b0;
                fail_d = 1'b1;
              end
              clear_c = 1'b1;
            end
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      brk_thr_q <= RST_BREAK_THR;
      start_thr_q <= RST_START_THR;
      win_len_q <= RST_WIN_LEN;
      ver_thr_q <= RST_VERIFY_THR;
      max_reads_q <= RST_MAX_READS;
      mask_ms_q <= RST_MASK_MS;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (reg_e'(cfg_index_i))
        REG_BREAK_THR:  brk_thr_q <= cfg_data_i;
        REG_START_THR:  start_thr_q <= cfg_data_i;
        REG_WIN_LEN:    win_len_q <= cfg_data_i;
        REG_VERIFY_THR: ver_thr_q <= cfg_data_i;
        REG_MAX_READS:  max_reads_q <= cfg_data_i[7:0];
        REG_MASK_MS:    mask_ms_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= C_IDLE;
      fsm_q <= CS_NORMAL;
      win_act_q <= 1'b0;
      win_rem_q <= 16'd0;
      mask_rem_q <= RST_MASK_MS;
      bp_q <= 5'd0;
      att_q <= 8'd0;
      succ_q <= 1'b0;
      fail_q <= 1'b0;
      valid_q <= '0;
      rd_valid_q <= 1'b0;
      scan_k_q <= '0;
      spike_q <= 1'b0;
      found_q <= 1'b0;
      all_q <= 1'b0;
      bad_q <= 1'b0;
      rv_q <= 1'b0;
    end else begin
      ctl_q <= ctl_d;
      fsm_q <= fsm_d;
      win_act_q <= win_act_d;
      win_rem_q <= win_rem_d;
      mask_rem_q <= mask_rem_d;
      bp_q <= bp_d;
      att_q <= att_d;
      succ_q <= succ_d;
      fail_q <= fail_d;
      rd_valid_q <= valid_q[raddr];
      rv_q <= (ctl_q == C_FIN);
      if (clear_c) begin
        valid_q <= '0;
      end else if (we) begin
        valid_q[AW'(dev_q)] <= 1'b1;
      end
      if (accept) begin
        scan_k_q <= '0;
        spike_q <= 1'b0;
        found_q <= 1'b0;
        all_q <= 1'b0;
        bad_q <= 1'b0;
      end else if (ctl_q == C_SCAN) begin
        scan_k_q <= scan_k_q + 1'b1;
        if (val > start_thr_q) begin
          spike_q <= 1'b1;
        end
        if (!found_q) begin
          if (val > brk_thr_q) begin
            found_q <= 1'b1;
            all_q <= 1'b1;
          end
        end else if (val <= brk_thr_q) begin
          all_q <= 1'b0;
        end
        if ((bp_q != 5'd0) && ((7'(scan_k_q) + 7'd1) >= 7'(bp_q)) &&
            (val > ver_thr_q)) begin
          bad_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= op_e'(operation_i);
      dev_q <= device_index_i;
      cnt_q <= error_count_i;
    end
    if ((ctl_q == C_SCAN) && !found_q && (val > brk_thr_q)) begin
      first_q <= scan_k_q;
    end
    if (ctl_q == C_FIN) begin
      ms_q <= chain_code(fsm_d);
      bpo_q <= bp_d;
      atto_q <= att_d;
      rec_q <= succ_d;
      stat_q <= status_c;
      rr_q <= reroute_c;
      cb_q <= cbreak_c;
      fr_q <= fraise_c;
      fc_q <= fclear_c;
      me_q <= (mask_rem_d == 16'd0);
    end
  end

  assign result_valid_o = rv_q;
  assign machine_state_o = ms_q;
  assign break_position_o = bpo_q;
  assign verify_attempts_o = atto_q;
  assign recovered_o = rec_q;
  assign status_report_o = stat_q;
  assign reroute_start_o = rr_q;
  assign comm_break_set_o = cb_q;
  assign fault_raise_o = fr_q;
  assign fault_clear_o = fc_q;
  assign mask_expired_o = me_q;

  a_result_after_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(ctl_q == C_FIN))
    else $error("result word without a finishing cycle");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("accepted word did not make the block busy");

  a_reroute_verify: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && reroute_start_o) |-> (machine_state_o == CODE_VERIFY))
    else $error("reroute issued outside the move to verifying");

  a_cbreak_reroute: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && comm_break_set_o) |-> reroute_start_o)
    else $error("comm break set without reroute");

  a_fclear_success: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && fault_clear_o) |->
      ((machine_state_o == CODE_NORMAL) && recovered_o))
    else $error("fault cleared without a recovered chain");

endmodule

// File: bench/dcbdr_checker.sv
// Scoreboard for the daisy chain break detector: keeps its own copy of the
// registers and chain state, predicts every result word and compares it field
// by field with what the block delivers. Depends on dcbdr_pkg.
module dcbdr_checker
  import dcbdr_pkg::*;
#(
  parameter int CHAIN_LENGTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [1:0]  operation_i,
  input  logic [3:0]  device_index_i,
  input  logic [7:0]  error_count_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        result_valid_i,
  input  logic [2:0]  machine_state_i,
  input  logic [4:0]  break_position_i,
  input  logic [7:0]  verify_attempts_i,
  input  logic        recovered_i,
  input  logic        status_report_i,
  input  logic        reroute_start_i,
  input  logic        comm_break_set_i,
  input  logic        fault_raise_i,
  input  logic        fault_clear_i,
  input  logic        mask_expired_i,
  output int          failures_o,
  output int          outstanding_o
);

  typedef struct packed {
    logic [2:0] mstate;
    logic [4:0] brk_pos;
    logic [7:0] attempts;
    logic       recovered;
    logic       status;
    logic       reroute;
    logic       comm_break;
    logic       f_raise;
    logic       f_clear;
    logic       mask_done;
  } chain_word_t;

  logic [15:0] brk_thr, start_thr, win_len, ver_thr, mask_len;
  logic [7:0]  max_reads;
  logic [15:0] sums [CHAIN_LENGTH];
  logic [2:0]  chain_state;
  logic        win_on, succ, fail_lat;
  logic [15:0] win_left, mask_left;
  logic [4:0]  brk_pos;
  logic [7:0]  attempts;
  chain_word_t expected_q[$];
  int          mismatches = 0;

  assign failures_o = mismatches;

  task automatic report_mismatch(string what, int got, int want);
    mismatches++;
    if (mismatches <= 100) begin
      $display("checker: %s is %0d, expected %0d", what, got, want);
    end
  endtask

  task automatic check_field(string what, int got, int want);
    if (got != want) begin
      report_mismatch(what, got, want);
    end
  endtask

  function automatic void clear_sums();
    for (int k = 0; k < CHAIN_LENGTH; k++) begin
      sums[k] = '0;
    end
  endfunction

  function automatic void restart_chain();
    mask_left = mask_len;
    win_on = 1'b0;
    win_left = '0;
    chain_state = CODE_NORMAL;
    brk_pos = '0;
    attempts = '0;
    succ = 1'b0;
    fail_lat = 1'b0;
    clear_sums();
  endfunction

  // Normal-state evaluation; returns 1 when a break is declared.
  function automatic logic decide_window();
    logic spike, tail_over;
    int   first;
    spike = 1'b0;
    if (!win_on) begin
      for (int k = 0; k < CHAIN_LENGTH; k++) begin
        if (sums[k] > start_thr) spike = 1'b1;
      end
      if (spike) begin
        win_on = 1'b1;
        win_left = win_len;
      end else begin
        clear_sums();
      end
      return 1'b0;
    end
    if (win_left != '0) return 1'b0;
    win_on = 1'b0;
    first = CHAIN_LENGTH;
    for (int k = CHAIN_LENGTH - 1; k >= 0; k--) begin
      if (sums[k] > brk_thr) first = k;
    end
    tail_over = (first < CHAIN_LENGTH);
    for (int k = 0; k < CHAIN_LENGTH; k++) begin
      if (k >= first && sums[k] <= brk_thr) tail_over = 1'b0;
    end
    if (tail_over) begin
      chain_state = CODE_BREAK;
      brk_pos = 5'(first + 1);
    end
    clear_sums();
    return tail_over;
  endfunction

  function automatic chain_word_t predict_word(op_e op, logic [3:0] dev, logic [7:0] cnt);
    chain_word_t w;
    logic [16:0] total;
    logic        bad;
    w = '0;
    case (op)
      OP_REPORT: begin
        if (dev < CHAIN_LENGTH) begin
          total = {1'b0, sums[dev]} + {9'd0, cnt};
          sums[dev] = total[16] ? 16'hFFFF : total[15:0];
        end
      end
      OP_TICK: begin
        if (win_on && win_left != '0) win_left = win_left - 16'd1;
        if (mask_left != '0) mask_left = mask_left - 16'd1;
      end
      OP_REINIT: begin
        restart_chain();
        w.status = 1'b1;
      end
      default: begin
        case (chain_state)
          CODE_NORMAL: begin
            if (!succ) w.f_raise = decide_window();
            else clear_sums();
          end
          CODE_BREAK: begin
            w.status = 1'b1;
            w.reroute = 1'b1;
            w.comm_break = (brk_pos > 5'd1);
            clear_sums();
            chain_state = CODE_VERIFY;
          end
          CODE_VERIFY: begin
            w.status = 1'b1;
            if (attempts >= max_reads) begin
              chain_state = CODE_FAILED;
            end else begin
              bad = 1'b0;
              if (brk_pos != '0) begin
                for (int k = 0; k < CHAIN_LENGTH; k++) begin
                  if (k >= brk_pos - 1 && sums[k] > ver_thr) bad = 1'b1;
                end
              end
              clear_sums();
              if (!bad) begin
                chain_state = CODE_SUCCESS;
                succ = 1'b1;
              end
              attempts = attempts + 8'd1;
            end
          end
          CODE_SUCCESS: begin
            w.status = 1'b1;
            w.f_clear = 1'b1;
            chain_state = CODE_NORMAL;
          end
          CODE_FAILED: begin
            if (!fail_lat) begin
              w.status = 1'b1;
              succ = 1'b0;
              fail_lat = 1'b1;
            end
            clear_sums();
          end
          default: ;
        endcase
      end
    endcase
    w.mstate = chain_state;
    w.brk_pos = brk_pos;
    w.attempts = attempts;
    w.recovered = succ;
    w.mask_done = (mask_left == '0);
    return w;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    chain_word_t want;
    if (!rst_ni) begin
      brk_thr = RST_BREAK_THR;
      start_thr = RST_START_THR;
      win_len = RST_WIN_LEN;
      ver_thr = RST_VERIFY_THR;
      max_reads = RST_MAX_READS;
      mask_len = RST_MASK_MS;
      restart_chain();
      expected_q.delete();
      outstanding_o <= 0;
    end else begin
      if (result_valid_i) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result word with nothing expected, state", machine_state_i, 0);
        end else begin
          want = expected_q.pop_front();
          check_field("machine_state", machine_state_i, want.mstate);
          check_field("break_position", break_position_i, want.brk_pos);
          check_field("verify_attempts", verify_attempts_i, want.attempts);
          check_field("recovered", recovered_i, want.recovered);
          check_field("status_report", status_report_i, want.status);
          check_field("reroute_start", reroute_start_i, want.reroute);
          check_field("comm_break_set", comm_break_set_i, want.comm_break);
          check_field("fault_raise", fault_raise_i, want.f_raise);
          check_field("fault_clear", fault_clear_i, want.f_clear);
          check_field("mask_expired", mask_expired_i, want.mask_done);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_BREAK_THR:  brk_thr = cfg_data_i;
          REG_START_THR:  start_thr = cfg_data_i;
          REG_WIN_LEN:    win_len = cfg_data_i;
          REG_VERIFY_THR: ver_thr = cfg_data_i;
          REG_MAX_READS:  max_reads = cfg_data_i[7:0];
          REG_MASK_MS:    mask_len = cfg_data_i;
          default: ;
        endcase
      end
      if (start_i && !busy_i) begin
        expected_q.push_back(predict_word(op_e'(operation_i), device_index_i, error_count_i));
      end
      outstanding_o <= expected_q.size();
    end
  end

endmodule

// File: bench/tb_daisy_chain_break_detect_recover.sv
// Testbench top for the daisy chain break detector: drives commands with
// random gaps and register writes, and gives the verdict.
// Depends on dcbdr_pkg, dcbdr_checker and the block itself.
module tb_daisy_chain_break_detect_recover;
  import dcbdr_pkg::*;

  localparam int CHAIN = 16;
  localparam int CYCLE_LIMIT = 400000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  operation_i = OP_REPORT;
  logic [3:0]  device_index_i = '0;
  logic [7:0]  error_count_i = '0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic        result_valid_o;
  logic [2:0]  machine_state_o;
  logic [4:0]  break_position_o;
  logic [7:0]  verify_attempts_o;
  logic        recovered_o;
  logic        status_report_o;
  logic        reroute_start_o;
  logic        comm_break_set_o;
  logic        fault_raise_o;
  logic        fault_clear_o;
  logic        mask_expired_o;

  int   failures, outstanding;
  int   cycles = 0;
  int   sent = 0;
  int   brk_cfg = RST_BREAK_THR;
  int   win_cfg = RST_WIN_LEN;
  int   max_cfg = RST_MAX_READS;
  logic quiet = 1'b0;

  always #6 clk_i = ~clk_i;

  daisy_chain_break_detect_recover #(
    .CHAIN_LENGTH(CHAIN)
  ) uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start(start),
    .busy(busy),
    .operation_i(operation_i),
    .device_index_i(device_index_i),
    .error_count_i(error_count_i),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i),
    .result_valid_o(result_valid_o),
    .machine_state_o(machine_state_o),
    .break_position_o(break_position_o),
    .verify_attempts_o(verify_attempts_o),
    .recovered_o(recovered_o),
    .status_report_o(status_report_o),
    .reroute_start_o(reroute_start_o),
    .comm_break_set_o(comm_break_set_o),
    .fault_raise_o(fault_raise_o),
    .fault_clear_o(fault_clear_o),
    .mask_expired_o(mask_expired_o)
  );

  dcbdr_checker #(
    .CHAIN_LENGTH(CHAIN)
  ) u_checker (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start_i(start),
    .busy_i(busy),
    .operation_i(operation_i),
    .device_index_i(device_index_i),
    .error_count_i(error_count_i),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_i(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i),
    .result_valid_i(result_valid_o),
    .machine_state_i(machine_state_o),
    .break_position_i(break_position_o),
    .verify_attempts_i(verify_attempts_o),
    .recovered_i(recovered_o),
    .status_report_i(status_report_o),
    .reroute_start_i(reroute_start_o),
    .comm_break_set_i(comm_break_set_o),
    .fault_raise_i(fault_raise_o),
    .fault_clear_i(fault_clear_o),
    .mask_expired_i(mask_expired_o),
    .failures_o(failures),
    .outstanding_o(outstanding)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  task automatic send_word(op_e op, logic [3:0] dev, logic [7:0] cnt);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 11);
    if ($urandom_range(0, 59) == 0) begin
      drain_results();
    end else if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    operation_i <= op;
    device_index_i <= dev;
    error_count_i <= cnt;
    do @(posedge clk_i); while (busy);
    sent++;
  endtask

  task automatic send_op(op_e op);
    send_word(op, 4'($urandom), 8'($urandom));
  endtask

  task automatic put_reg(reg_e idx, logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic configure(int brk, int start_thr, int win, int ver, logic [15:0] max_word,
                           int mask);
    put_reg(REG_BREAK_THR, 16'(brk));
    put_reg(REG_START_THR, 16'(start_thr));
    put_reg(REG_WIN_LEN, 16'(win));
    put_reg(REG_VERIFY_THR, 16'(ver));
    put_reg(REG_MAX_READS, max_word);
    put_reg(REG_MASK_MS, 16'(mask));
    cfg_valid_i <= 1'b0;
    brk_cfg = brk;
    win_cfg = win;
    max_cfg = max_word[7:0];
  endtask

  task automatic pump_device(int dev, int total);
    int chunk;
    while (total > 0) begin
      chunk = (total > 255) ? 255 : total;
      send_word(OP_REPORT, 4'(dev), 8'(chunk));
      total -= chunk;
    end
  endtask

  // Builds up errors on the tail of the chain, ticks the window down and then
  // walks the break, verify and outcome states, with some noise mixed in.
  task automatic run_sequence();
    int   first, ticks, evals;
    logic dirty;
    quiet = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 1) == 0) send_op(OP_REINIT);
    first = $urandom_range(0, CHAIN - 1);
    for (int dev = first; dev < CHAIN; dev++) begin
      if (brk_cfg < 765 && $urandom_range(0, 7) != 0) begin
        pump_device(dev, brk_cfg + 1 + $urandom_range(0, 20));
      end else begin
        send_word(OP_REPORT, 4'(dev), 8'($urandom));
      end
    end
    if (first > 0 && $urandom_range(0, 3) == 0) begin
      send_word(OP_REPORT, 4'($urandom_range(0, first - 1)), 8'($urandom));
    end
    send_op(OP_EVAL);
    ticks = (win_cfg <= 40) ? win_cfg : $urandom_range(0, 5);
    if ($urandom_range(0, 5) == 0) ticks = $urandom_range(0, ticks);
    repeat (ticks) begin
      if ($urandom_range(0, 4) == 0) begin
        send_word(OP_REPORT, 4'($urandom), 8'($urandom_range(0, 3)));
      end
      send_op(OP_TICK);
    end
    send_op(OP_EVAL);
    dirty = ($urandom_range(0, 2) == 0);
    evals = (max_cfg < 8) ? max_cfg + 3 : $urandom_range(3, 12);
    repeat (evals) begin
      if (dirty) begin
        send_word(OP_REPORT, 4'($urandom_range(first, CHAIN - 1)), 8'($urandom_range(200, 255)));
      end else if ($urandom_range(0, 3) == 0) begin
        send_op(OP_REPORT);
      end
      send_op(OP_EVAL);
    end
  endtask

  initial begin : stimulus
    int target;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_word(OP_REPORT, 4'd0, 8'd255);
    send_word(OP_REPORT, 4'd15, 8'd0);
    send_word(OP_REPORT, 4'd5, 8'hAA);
    send_word(OP_REPORT, 4'd10, 8'h55);
    send_op(OP_EVAL);
    send_op(OP_TICK);
    send_op(OP_EVAL);
    send_word(OP_REPORT, 4'd3, 8'd1);
    send_op(OP_REINIT);
    send_op(OP_TICK);
    send_op(OP_EVAL);
    send_word(OP_REPORT, 4'd7, 8'd3);
    send_op(OP_EVAL);

    for (int phase = 0; phase < 7; phase++) begin
      drain_results();
      case (phase)
        0: configure(25, 5, 3, 5, 16'd5, 4);
        1: configure(0, 0, 0, 0, 16'd0, 0);
        2: configure(65535, 65535, 65535, 65535, 16'hFFFF, 65535);
        3: configure(65534, 0, 1, 0, 16'h5A02, 0);
        default: begin
          configure(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 700),
                    ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 60),
                    $urandom_range(0, 12),
                    ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 40),
                    {8'($urandom), 8'($urandom_range(1, 6))},
                    ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 12));
        end
      endcase
      if (phase == 3) begin
        // One device driven past the 16-bit sum limit to show saturation.
        send_op(OP_REINIT);
        repeat (258) send_word(OP_REPORT, 4'd15, 8'd255);
        send_op(OP_EVAL);
        send_op(OP_TICK);
        repeat (4) send_op(OP_EVAL);
      end
      target = sent + 70;
      while (sent < target) begin
        if ($urandom_range(0, 4) == 0) begin
          quiet = 1'b0;
          repeat ($urandom_range(1, 6)) send_op(op_e'($urandom_range(0, 3)));
        end else begin
          run_sequence();
        end
      end
    end

    drain_results();
    repeat (40) @(posedge clk_i);
    if (failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
